// ===== hdl/cnv_pkg.sv =====
// Shared types and constants of the 3x3 stencil convolution filter.
// Used by cnv_front, cnv_queue, cnv_back and conv3x3_stencil_filter.
// No dependencies.
package cnv_pkg;

  // Frame geometry limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_DIM    = 3;
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 11;

  // Data formats
  localparam int SMP_W   = 16;                  // unsigned Q8.8 sample
  localparam int COEF_W  = 16;                  // signed Q2.14 coefficient
  localparam int PROD_W  = SMP_W + 1 + COEF_W;  // exact signed product
  localparam int ROW_W   = PROD_W + 2;          // sum of three products
  localparam int ACC_W   = PROD_W + 4;          // sum of nine products
  localparam int FRAC_SH = 14;
  localparam int CFG_W   = 48;
  localparam int OUT_TDATA_W = 40;

  // Decoupling queue
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QLW    = $clog2(QDEPTH + 1);

  // Configuration register indexes
  localparam logic [2:0] CFG_COEF_ABOVE  = 3'd0;
  localparam logic [2:0] CFG_COEF_MIDDLE = 3'd1;
  localparam logic [2:0] CFG_COEF_BELOW  = 3'd2;
  localparam logic [2:0] CFG_FRAME_W     = 3'd3;
  localparam logic [2:0] CFG_FRAME_H     = 3'd4;

  // 3x3 window and kernel, indexed [row][column], row 0 is the oldest line
  typedef logic [2:0][2:0][SMP_W-1:0]  win_t;
  typedef logic [2:0][2:0][COEF_W-1:0] coef_t;

  // Active geometry, held as last index of a row and of a frame
  typedef struct packed {
    logic [XW-1:0] w_m1;
    logic [YW-1:0] h_m1;
  } geom_t;

  // One interior pixel waiting for its dot product
  typedef struct packed {
    win_t          win;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic          eof;
  } item_t;

  // Queue fill status seen by the front end
  typedef struct packed {
    logic [QLW-1:0] level;
    logic           empty;
  } qstat_t;

  // Clamp a written dimension to MIN_DIM..hi and return it minus one
  function automatic logic [XW-1:0] clamp_m1(logic [DIM_W-1:0] v, logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] c;
    logic [DIM_W-1:0] m;
    if (v < DIM_W'(MIN_DIM)) begin
      c = DIM_W'(MIN_DIM);
    end else if (v > hi) begin
      c = hi;
    end else begin
      c = v;
    end
    m = c - DIM_W'(1);
    return m[XW-1:0];
  endfunction

endpackage

// ===== hdl/cnv_front.sv =====
// Front end of the stencil filter: pixel counters, line memory and window.
// Classifies each sample and pushes interior windows into the queue.
// Depends on cnv_pkg.
module cnv_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cnv_pkg::geom_t            geom_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [cnv_pkg::SMP_W-1:0] in_sample_i,
  input  logic                      in_sof_i,
  input  cnv_pkg::qstat_t           qstat_i,
  output logic                      push_o,
  output cnv_pkg::item_t            push_item_o
);

  localparam int WORD_W = 2 * cnv_pkg::SMP_W;

  // Line memory word: older line in the upper half, newer line in the lower
  logic [WORD_W-1:0] line_mem [cnv_pkg::MAX_WIDTH];
  logic [WORD_W-1:0] rdata_q;

  logic [cnv_pkg::XW-1:0] col_q, col_d, x_cur;
  logic [cnv_pkg::YW-1:0] row_q, row_d, y_cur;
  logic accept;

  logic                      f1_valid_q;
  logic [cnv_pkg::SMP_W-1:0] f1_sample_q;
  logic [cnv_pkg::XW-1:0]    f1_x_q;
  logic [cnv_pkg::YW-1:0]    f1_y_q;
  logic                      f1_interior_q;
  logic                      f1_eof_q;

  logic              byp_q;
  logic [WORD_W-1:0] byp_data_q;
  logic [WORD_W-1:0] rd_word;
  logic [WORD_W-1:0] wr_word;

  cnv_pkg::win_t win_q, win_d;

  // Take a transaction only when the queue has room for it and the one in flight
  assign in_ready_o = ({1'b0, qstat_i.level} + (cnv_pkg::QLW + 1)'(f1_valid_q))
                      < (cnv_pkg::QLW + 1)'(cnv_pkg::QDEPTH);
  assign accept     = in_valid_i & in_ready_o;

  // Coordinates of the incoming sample and of the next one
  always_comb begin
    if (in_sof_i || (col_q > geom_i.w_m1)) begin
      x_cur = '0;
    end else begin
      x_cur = col_q;
    end
    if (in_sof_i || (row_q > geom_i.h_m1)) begin
      y_cur = '0;
    end else begin
      y_cur = row_q;
    end
    if (x_cur == geom_i.w_m1) begin
      col_d = '0;
      row_d = (y_cur == geom_i.h_m1) ? '0 : y_cur + cnv_pkg::YW'(1);
    end else begin
      col_d = x_cur + cnv_pkg::XW'(1);
      row_d = y_cur;
    end
  end

  // Advance counters and the read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      f1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else begin
      f1_valid_q <= accept;
      byp_q      <= accept & f1_valid_q & (x_cur == f1_x_q);
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  // Hold the sample and its class next to the memory read
  always_ff @(posedge clk_i) begin
    byp_data_q <= wr_word;
    if (accept) begin
      f1_sample_q   <= in_sample_i;
      f1_x_q        <= x_cur;
      f1_y_q        <= y_cur;
      f1_interior_q <= (x_cur >= cnv_pkg::XW'(2)) && (y_cur >= cnv_pkg::YW'(2));
      f1_eof_q      <= (x_cur == geom_i.w_m1) && (y_cur == geom_i.h_m1);
    end
  end

  // Line memory: read on accept, write back in the following cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q <= line_mem[x_cur];
    end
    if (f1_valid_q) begin
      line_mem[f1_x_q] <= wr_word;
    end
  end

  // Forward a write that lands on the address read in the same cycle
  assign rd_word = byp_q ? byp_data_q : rdata_q;
  assign wr_word = {rd_word[cnv_pkg::SMP_W-1:0], f1_sample_q};

  // Shift the window one column left and load the new column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
    end
    win_d[0][2] = rd_word[WORD_W-1:cnv_pkg::SMP_W];
    win_d[1][2] = rd_word[cnv_pkg::SMP_W-1:0];
    win_d[2][2] = f1_sample_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (f1_valid_q) begin
      win_q <= win_d;
    end
  end

  // Push interior pixels, centre one step back in both directions
  assign push_o            = f1_valid_q & f1_interior_q;
  assign push_item_o.win   = win_d;
  assign push_item_o.x     = f1_x_q - cnv_pkg::XW'(1);
  assign push_item_o.y     = f1_y_q - cnv_pkg::YW'(1);
  assign push_item_o.eof   = f1_eof_q;

endmodule

// ===== hdl/cnv_queue.sv =====
// Short queue between the front end and the arithmetic back end.
// Register based, one push and one pop per cycle.
// Depends on cnv_pkg.
module cnv_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cnv_pkg::item_t  push_item_i,
  input  logic            pop_i,
  output cnv_pkg::item_t  head_o,
  output cnv_pkg::qstat_t stat_o
);

  cnv_pkg::item_t entries_q [cnv_pkg::QDEPTH];
  logic [cnv_pkg::QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [cnv_pkg::QLW-1:0] level_q;
  logic do_pop;

  assign do_pop       = pop_i & (level_q != '0);
  assign head_o       = entries_q[rd_ptr_q];
  assign stat_o.level = level_q;
  assign stat_o.empty = (level_q == '0);

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + cnv_pkg::QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + cnv_pkg::QAW'(1);
      end
      unique case ({push_i, do_pop})
        2'b10:   level_q <= level_q + cnv_pkg::QLW'(1);
        2'b01:   level_q <= level_q - cnv_pkg::QLW'(1);
        default: level_q <= level_q;
      endcase
    end
  end

endmodule

// ===== hdl/cnv_back.sv =====
// Back end of the stencil filter: nine products, row sums, total and
// saturation, ending in the output register. Depends on cnv_pkg.
module cnv_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cnv_pkg::coef_t            coef_i,
  input  cnv_pkg::qstat_t           qstat_i,
  input  cnv_pkg::item_t            head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [cnv_pkg::SMP_W-1:0] out_value_o,
  output logic [cnv_pkg::XW-1:0]    out_x_o,
  output logic [cnv_pkg::YW-1:0]    out_y_o,
  output logic                      out_eof_o
);

  typedef logic signed [cnv_pkg::PROD_W-1:0] prod_t;
  typedef logic signed [cnv_pkg::ROW_W-1:0]  rsum_t;

  // Product stage
  logic                   p_valid_q;
  prod_t                  p_q [3][3];
  logic [cnv_pkg::XW-1:0] p_x_q;
  logic [cnv_pkg::YW-1:0] p_y_q;
  logic                   p_eof_q;

  // Row sum stage
  logic                   a_valid_q;
  rsum_t                  a_q [3];
  logic [cnv_pkg::XW-1:0] a_x_q;
  logic [cnv_pkg::YW-1:0] a_y_q;
  logic                   a_eof_q;

  // Output register
  logic                      o_valid_q;
  logic [cnv_pkg::SMP_W-1:0] o_value_q;
  logic [cnv_pkg::XW-1:0]    o_x_q;
  logic [cnv_pkg::YW-1:0]    o_y_q;
  logic                      o_eof_q;

  logic ld_o, ld_a, ld_p;
  prod_t prod [3][3];
  rsum_t rsum [3];
  logic signed [cnv_pkg::ACC_W-1:0] acc;
  logic [cnv_pkg::SMP_W-1:0] sat;

  // Each stage loads when it is empty or its successor loads
  assign ld_o  = ~o_valid_q | out_ready_i;
  assign ld_a  = ~a_valid_q | ld_o;
  assign ld_p  = ~p_valid_q | ld_a;
  assign pop_o = ld_p & ~qstat_i.empty;

  // Nine sample by coefficient products
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod[r][c] = $signed({1'b0, head_i.win[r][c]}) * $signed(coef_i[r][c]);
      end
    end
  end

  // Sum each row of products
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rsum[r] = cnv_pkg::ROW_W'(p_q[r][0]) + cnv_pkg::ROW_W'(p_q[r][1])
              + cnv_pkg::ROW_W'(p_q[r][2]);
    end
  end

  // Total, drop the fraction and clamp to the unsigned sample range
  always_comb begin
    acc = cnv_pkg::ACC_W'(a_q[0]) + cnv_pkg::ACC_W'(a_q[1]) + cnv_pkg::ACC_W'(a_q[2]);
    if (acc[cnv_pkg::ACC_W-1]) begin
      sat = '0;
    end else if (|acc[cnv_pkg::ACC_W-2:cnv_pkg::FRAC_SH+cnv_pkg::SMP_W]) begin
      sat = '1;
    end else begin
      sat = acc[cnv_pkg::FRAC_SH+cnv_pkg::SMP_W-1:cnv_pkg::FRAC_SH];
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      a_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (ld_p) begin
        p_valid_q <= ~qstat_i.empty;
      end
      if (ld_a) begin
        a_valid_q <= p_valid_q;
      end
      if (ld_o) begin
        o_valid_q <= a_valid_q;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (ld_p) begin
      p_q     <= prod;
      p_x_q   <= head_i.x;
      p_y_q   <= head_i.y;
      p_eof_q <= head_i.eof;
    end
    if (ld_a) begin
      a_q     <= rsum;
      a_x_q   <= p_x_q;
      a_y_q   <= p_y_q;
      a_eof_q <= p_eof_q;
    end
    if (ld_o) begin
      o_value_q <= sat;
      o_x_q     <= a_x_q;
      o_y_q     <= a_y_q;
      o_eof_q   <= a_eof_q;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_value_o = o_value_q;
  assign out_x_o     = o_x_q;
  assign out_y_o     = o_y_q;
  assign out_eof_o   = o_eof_q;

endmodule

// ===== hdl/conv3x3_stencil_filter.sv =====
// Streaming 3x3 convolution over a raster frame: one sample per cycle in,
// one interior pixel per cycle out while the output is ready and the queue has
// room. Samples pass the read stage, queue, product, row sum and output registers;
// throughput is at best one sample a cycle, set by the single read and single write
// port of the line memory. Reset clears counters, window, queue and valid bits,
// sets kernel to zero and geometry to 1024x1024; the line memory is not cleared
// and needs no clearing pass. Depends on cnv_pkg, cnv_front, cnv_queue and cnv_back.
module conv3x3_stencil_filter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration writes
  input  logic                            cfg_we_i,
  input  logic [2:0]                      cfg_idx_i,
  input  logic [cnv_pkg::CFG_W-1:0]       cfg_data_i,
  // Sample stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [cnv_pkg::SMP_W-1:0]       s_axis_tdata,  // [15:0] sample
  input  logic                            s_axis_tuser,  // [0] start_of_frame
  // Result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [cnv_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [15:0] out_value,
                                                         // [25:16] out_x,
                                                         // [35:26] out_y, rest 0
  output logic                            m_axis_tlast   // end_of_frame
);

  localparam int PAD_W = cnv_pkg::OUT_TDATA_W - cnv_pkg::SMP_W - cnv_pkg::XW - cnv_pkg::YW;

  cnv_pkg::coef_t  coef_q;
  cnv_pkg::geom_t  geom_q;
  cnv_pkg::qstat_t qstat;
  cnv_pkg::item_t  push_item, head;
  logic            push, pop;

  logic [cnv_pkg::SMP_W-1:0] out_value;
  logic [cnv_pkg::XW-1:0]    out_x;
  logic [cnv_pkg::YW-1:0]    out_y;

  // Configuration registers; geometry is stored clamped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q      <= '0;
      geom_q.w_m1 <= cnv_pkg::XW'(cnv_pkg::MAX_WIDTH - 1);
      geom_q.h_m1 <= cnv_pkg::YW'(cnv_pkg::MAX_HEIGHT - 1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cnv_pkg::CFG_COEF_ABOVE:  coef_q[0] <= cfg_data_i;
        cnv_pkg::CFG_COEF_MIDDLE: coef_q[1] <= cfg_data_i;
        cnv_pkg::CFG_COEF_BELOW:  coef_q[2] <= cfg_data_i;
        cnv_pkg::CFG_FRAME_W:
          geom_q.w_m1 <= cnv_pkg::clamp_m1(cfg_data_i[cnv_pkg::DIM_W-1:0],
                                           cnv_pkg::DIM_W'(cnv_pkg::MAX_WIDTH));
        cnv_pkg::CFG_FRAME_H:
          geom_q.h_m1 <= cnv_pkg::clamp_m1(cfg_data_i[cnv_pkg::DIM_W-1:0],
                                           cnv_pkg::DIM_W'(cnv_pkg::MAX_HEIGHT));
        default: ;
      endcase
    end
  end

  cnv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_sample_i (s_axis_tdata),
    .in_sof_i    (s_axis_tuser),
    .qstat_i     (qstat),
    .push_o      (push),
    .push_item_o (push_item)
  );

  cnv_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (qstat)
  );

  cnv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef_q),
    .qstat_i     (qstat),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (out_value),
    .out_x_o     (out_x),
    .out_y_o     (out_y),
    .out_eof_o   (m_axis_tlast)
  );

  // Pack the result fields, lowest field first
  assign m_axis_tdata = {{PAD_W{1'b0}}, out_y, out_x, out_value};

endmodule

// ===== tb/sv/conv3x3_stencil_filter_chk.sv =====
// Scoreboard for the 3x3 stencil filter: tracks configuration writes, predicts
// each interior pixel from accepted samples and checks the result stream.
// Depends on cnv_pkg.
module conv3x3_stencil_filter_chk
  import cnv_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [SMP_W-1:0]       s_axis_tdata,  // [15:0] sample
  input  logic                   s_axis_tuser,  // [0] start_of_frame
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [15:0] value, [25:16] x, [35:26] y
  input  logic                   m_axis_tlast,  // end_of_frame
  output int                     mismatch_cnt,
  output int                     checked_cnt,
  output int                     pending_cnt
);

  typedef struct packed {
    logic [SMP_W-1:0] value;
    logic [XW-1:0]    x;
    logic [YW-1:0]    y;
    logic             eof;
  } pixel_t;

  pixel_t pixels_due[$];

  // Shadow configuration and filter state
  logic [CFG_W-1:0] kernel_rows [3];
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [SMP_W-1:0] older_line [MAX_WIDTH];
  logic [SMP_W-1:0] newer_line [MAX_WIDTH];
  logic [SMP_W-1:0] win [9];
  int unsigned      col_cnt;
  int unsigned      row_cnt;
  int               errs;
  int               seen;

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the window by one sample; return 1 when an interior pixel completes
  function automatic bit convolve_sample(input logic [SMP_W-1:0] smp, input logic sof,
                                         output pixel_t px);
    int unsigned w, h, x, y;
    int          r, c;
    longint      acc;
    bit          emit;
    logic signed [COEF_W-1:0] cf;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    if (sof) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    if (col_cnt >= w) col_cnt = 0;
    if (row_cnt >= h) row_cnt = 0;
    x = col_cnt;
    y = row_cnt;
    for (r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = older_line[x];
    win[5] = newer_line[x];
    win[8] = smp;
    older_line[x] = newer_line[x];
    newer_line[x] = smp;
    px   = '0;
    emit = (x >= 2) && (y >= 2);
    if (emit) begin
      acc = 0;
      for (r = 0; r < 3; r++) begin
        for (c = 0; c < 3; c++) begin
          cf  = kernel_rows[r][COEF_W*c +: COEF_W];
          acc += longint'(win[r*3+c]) * longint'(cf);
        end
      end
      // Negative sums clip to zero, large ones to full scale
      if (acc < 0) px.value = '0;
      else if ((acc >>> FRAC_SH) > 65535) px.value = '1;
      else px.value = SMP_W'(acc >>> FRAC_SH);
      px.x   = XW'(x - 1);
      px.y   = YW'(y - 1);
      px.eof = (x == w - 1) && (y == h - 1);
    end
    col_cnt = x + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = y + 1;
      if (row_cnt >= h) row_cnt = 0;
    end
    return emit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t px;
    pixel_t due;
    int     i;
    if (!rst_ni) begin
      kernel_rows[0] = '0;
      kernel_rows[1] = '0;
      kernel_rows[2] = '0;
      width_reg  = DIM_W'(MAX_WIDTH);
      height_reg = DIM_W'(MAX_HEIGHT);
      for (i = 0; i < MAX_WIDTH; i++) begin
        older_line[i] = '0;
        newer_line[i] = '0;
      end
      for (i = 0; i < 9; i++) win[i] = '0;
      col_cnt = 0;
      row_cnt = 0;
      errs = 0;
      seen = 0;
      pixels_due.delete();
      mismatch_cnt <= 0;
      checked_cnt  <= 0;
      pending_cnt  <= 0;
    end else begin
      // Mirror register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_COEF_ABOVE, CFG_COEF_MIDDLE, CFG_COEF_BELOW: kernel_rows[cfg_idx_i] = cfg_data_i;
          CFG_FRAME_W: width_reg  = cfg_data_i[DIM_W-1:0];
          CFG_FRAME_H: height_reg = cfg_data_i[DIM_W-1:0];
          default: ;
        endcase
      end
      // Check the result transaction against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        seen++;
        if (pixels_due.size() == 0) begin
          errs++;
          $error("out_value: expected no pixel, got %h", m_axis_tdata[15:0]);
        end else begin
          due = pixels_due.pop_front();
          if (m_axis_tdata[15:0] !== due.value) begin
            errs++;
            $error("out_value: expected %h, got %h", due.value, m_axis_tdata[15:0]);
          end
          if (m_axis_tdata[25:16] !== due.x) begin
            errs++;
            $error("out_x: expected %0d, got %0d", due.x, m_axis_tdata[25:16]);
          end
          if (m_axis_tdata[35:26] !== due.y) begin
            errs++;
            $error("out_y: expected %0d, got %0d", due.y, m_axis_tdata[35:26]);
          end
          if (m_axis_tlast !== due.eof) begin
            errs++;
            $error("end_of_frame: expected %b, got %b", due.eof, m_axis_tlast);
          end
          if (m_axis_tdata[OUT_TDATA_W-1:36] !== '0) begin
            errs++;
            $error("tdata padding: expected 0, got %h", m_axis_tdata[OUT_TDATA_W-1:36]);
          end
        end
      end
      // Predict from the sample transaction
      if (s_axis_tvalid && s_axis_tready) begin
        if (convolve_sample(s_axis_tdata, s_axis_tuser, px)) pixels_due.push_back(px);
      end
      mismatch_cnt <= errs;
      checked_cnt  <= seen;
      pending_cnt  <= pixels_due.size();
    end
  end

endmodule

// ===== tb/sv/conv3x3_stencil_filter_tb.sv =====
// Testbench top for the 3x3 stencil filter: clock, reset, register writes,
// sample traffic with bursts and stalls, and the final verdict.
// Depends on cnv_pkg, conv3x3_stencil_filter and conv3x3_stencil_filter_chk.
module conv3x3_stencil_filter_tb;
  import cnv_pkg::*;

  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 250;

  typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_ALTERNATE} rx_mode_e;
  typedef enum int {KS_FULL, KS_SMALL, KS_SPARSE} kernel_style_e;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [2:0]             cfg_idx_i     = CFG_COEF_ABOVE;
  logic [CFG_W-1:0]       cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [SMP_W-1:0]       s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  int mismatch_cnt;
  int checked_cnt;
  int pending_cnt;
  int holds_asked  = 0;
  int idle_cycles  = 0;
  int burst_left   = 0;
  int samples_sent = 0;
  bit sof_due      = 1'b0;

  conv3x3_stencil_filter i_dut (.*);

  conv3x3_stencil_filter_chk i_chk (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Abort when neither stream moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result-side backpressure: random modes, plus long hold-offs on request
  initial begin : rx_pattern
    rx_mode_e mode;
    int       mode_left;
    int       hold_left;
    int       holds_served;
    int       phase;
    mode         = RX_ALWAYS;
    mode_left    = 0;
    hold_left    = 0;
    holds_served = 0;
    phase        = 0;
    forever begin
      @(posedge clk_i);
      if (holds_asked != holds_served) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        phase++;
        case (mode)
          RX_ALWAYS: m_axis_tready <= 1'b1;
          RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:   m_axis_tready <= phase[1];
        endcase
      end
    end
  end

  function automatic logic [SMP_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return SMP_W'($urandom_range(0, 255));
      default: return SMP_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_kernel_row(input kernel_style_e style);
    logic [CFG_W-1:0] row;
    int               c;
    row = '0;
    for (c = 0; c < 3; c++) begin
      case (style)
        KS_FULL:  row[COEF_W*c +: COEF_W] = COEF_W'($urandom);
        // roughly -0.125..+0.125, keeps most sums inside the output range
        KS_SMALL: row[COEF_W*c +: COEF_W] = COEF_W'($urandom_range(0, 16'h1000) - 16'h0800);
        default: begin
          if ($urandom_range(0, 2) == 0) begin
            row[COEF_W*c +: COEF_W] = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
          end
        end
      endcase
    end
    return row;
  endfunction

  // Offer one sample; gaps fall between bursts of random length
  task automatic send_sample(input logic [SMP_W-1:0] smp, input logic sof);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200) :
                                                 $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= sof || sof_due;
    sof_due = 1'b0;
    do @(posedge clk_i); while (!s_axis_tready);
    samples_sent++;
  endtask

  task automatic send_run(input int count, input bit lead_sof, input int restart_at);
    int k;
    for (k = 0; k < count; k++) begin
      send_sample(pick_sample(), (k == 0 && lead_sof) || k == restart_at);
    end
  endtask

  // Hold the input until every predicted pixel has left, then let the pipe empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all five registers; the next frame must restart at the origin
  task automatic program_filter(input logic [CFG_W-1:0] above, input logic [CFG_W-1:0] middle,
                                input logic [CFG_W-1:0] below, input logic [DIM_W-1:0] w,
                                input logic [DIM_W-1:0] h);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_COEF_ABOVE;
    cfg_data_i <= above;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_COEF_MIDDLE;
    cfg_data_i <= middle;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_COEF_BELOW;
    cfg_data_i <= below;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_FRAME_W;
    cfg_data_i <= CFG_W'(w);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_FRAME_H;
    cfg_data_i <= CFG_W'(h);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sof_due = 1'b1;
  endtask

  initial begin : stimulus
    int            w;
    int            h;
    int            k;
    int            total;
    int            base;
    kernel_style_e style;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry and zero kernel: part of the first row, nothing comes out
    send_run(24, 1'b0, -1);
    settle();

    // Identity kernel on a clamped 3x3 frame: centre sample passes through
    program_filter('0, 48'h0000_4000_0000, '0, 11'd0, 11'd2);
    for (k = 0; k < 9; k++) send_sample((k == 4) ? '1 : '0, k == 0);
    settle();

    // Largest positive kernel on full-scale samples: clip high
    program_filter({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, 11'd3, 11'd1);
    for (k = 0; k < 9; k++) send_sample('1, k == 0);
    settle();

    // Most negative kernel on full-scale samples: clip to zero
    program_filter({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, 11'd2, 11'd3);
    for (k = 0; k < 9; k++) send_sample('1, k == 0);
    settle();

    // Oversized width written: the row stays open past the written low bits
    program_filter(pick_kernel_row(KS_SMALL), pick_kernel_row(KS_SMALL),
                   pick_kernel_row(KS_SMALL), 11'd2047, 11'd3);
    send_run(30, 1'b1, -1);
    settle();

    // Tallest frame, oversized height written, three columns, first rows only
    program_filter(pick_kernel_row(KS_FULL), pick_kernel_row(KS_SMALL),
                   pick_kernel_row(KS_SPARSE), 11'd1, 11'd2047);
    send_run(3 * 16, 1'b1, -1);
    settle();

    // Long receiver hold-off while samples keep coming, so the input backs up
    program_filter(pick_kernel_row(KS_SMALL), pick_kernel_row(KS_SMALL),
                   pick_kernel_row(KS_SMALL), 11'd8, 11'd6);
    holds_asked <= holds_asked + 1;
    send_run(2 * 8 * 6, 1'b1, -1);
    settle();

    // Random kernels and small frames; mostly whole frames, some broken ones
    base = samples_sent;
    while (samples_sent - base < RANDOM_ITEMS) begin
      style = kernel_style_e'($urandom_range(0, 2));
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 32) : $urandom_range(3, 10);
      h = $urandom_range(3, 7);
      program_filter(pick_kernel_row(style), pick_kernel_row(style), pick_kernel_row(style),
                     DIM_W'(w), DIM_W'(h));
      repeat ($urandom_range(1, 3)) begin
        total = w * h;
        case ($urandom_range(0, 9))
          0:       send_run($urandom_range(1, total - 1), 1'b1, -1);
          1:       send_run(total + $urandom_range(1, 2 * w), $urandom_range(0, 1), -1);
          2:       send_run(total, 1'b1, $urandom_range(1, total - 1));
          default: send_run(total, 1'b1, -1);
        endcase
      end
      settle();
    end

    $display("Sent %0d samples, checked %0d pixels: reset and clamped geometry, identity",
             samples_sent, checked_cnt);
    $display("and clipping kernels, restarts, overruns, random stalls and a long hold-off.");
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/cnv_pkg.sv
hdl/cnv_front.sv
hdl/cnv_queue.sv
hdl/cnv_back.sv
hdl/conv3x3_stencil_filter.sv
tb/sv/conv3x3_stencil_filter_chk.sv
tb/sv/conv3x3_stencil_filter_tb.sv
